[hw/rtl/stimulus_phase_sequencer_core_defines.svh]
// Assertion macros used by the sequencer core RTL.
`ifndef STIMULUS_PHASE_SEQUENCER_CORE_DEFINES_SVH
`define STIMULUS_PHASE_SEQUENCER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/sps_pkg.sv]
package sps_pkg;

    // Phase codes
    localparam logic [2:0] PH_OUTSIDE  = 3'd0;
    localparam logic [2:0] PH_DELAYING = 3'd1;
    localparam logic [2:0] PH_STIM     = 3'd2;
    localparam logic [2:0] PH_PAUSE    = 3'd3;
    localparam logic [2:0] PH_REFRACT  = 3'd4;

    // Level clamp limits
    localparam logic [7:0] LEVEL_MIN = 8'd2;
    localparam logic [7:0] LEVEL_MAX = 8'd7;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_DELAY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_DELAY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STIM_LENGTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REQUESTED_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STIM_MODE       = 3'd5;

    typedef struct packed {
        logic [31:0] entry_delay;
        logic [31:0] pause_delay;
        logic [31:0] stim_length;
        logic [31:0] refractory_time;
        logic [7:0]  requested_level;
        logic        stim_mode;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] last_change;
        logic [2:0]  drive;
        logic [31:0] entries;
        logic [31:0] stimuli;
        logic [31:0] first_stim;
        logic [31:0] good_count;
        logic [31:0] bad_count;
    } state_t;

    typedef struct packed {
        state_t st;
        logic   written;
    } result_t;

    // Requested level limited to the usable range; low requests mean off
    function automatic logic [2:0] clamp_level(input logic [7:0] req);
        logic [2:0] lvl;
        if (req < LEVEL_MIN) begin
            lvl = 3'd0;
        end else if (req > LEVEL_MAX) begin
            lvl = LEVEL_MAX[2:0];
        end else begin
            lvl = req[2:0];
        end
        return lvl;
    endfunction

endpackage

[hw/rtl/stimulus_phase_sequencer_core.sv]
// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_valid / s_ready  | timestamp, stim_request, bad_frame
// m_        | out       | m_valid / m_ready  | phase, drive level/written, counters
// cfg_      | in        | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle while s_ready is high: step logic sits between the state
// and result registers; an accepted result goes to the output register or skid.
// A two-deep result buffer (output register plus skid) keeps s_ready high
// while one result waits; s_ready drops only when both are full.
// Reset (aresetn low, synchronous) clears state, configuration and buffers.
module stimulus_phase_sequencer_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [31:0]                    s_timestamp,
    input  logic                           s_stim_request,
    input  logic                           s_bad_frame,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_phase,
    output logic [2:0]                     m_drive_level,
    output logic                           m_drive_written,
    output logic [31:0]                    m_entry_count,
    output logic [31:0]                    m_stim_count,
    output logic [31:0]                    m_first_stim_time,
    output logic [31:0]                    m_good_frames,
    output logic [31:0]                    m_bad_frames
);

`include "stimulus_phase_sequencer_core_defines.svh"

    sps_pkg::cfg_t    cfg_reg;
    sps_pkg::state_t  st_reg;
    sps_pkg::state_t  st_next;
    logic             written_next;
    sps_pkg::result_t res_next;
    sps_pkg::result_t out_reg;
    sps_pkg::result_t skid_reg;
    logic             m_valid_reg;
    logic             skid_valid_reg;
    logic             push;
    logic             pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                sps_pkg::REG_ENTRY_DELAY:     cfg_reg.entry_delay     <= cfg_wdata;
                sps_pkg::REG_PAUSE_DELAY:     cfg_reg.pause_delay     <= cfg_wdata;
                sps_pkg::REG_STIM_LENGTH:     cfg_reg.stim_length     <= cfg_wdata;
                sps_pkg::REG_REFRACTORY_TIME: cfg_reg.refractory_time <= cfg_wdata;
                sps_pkg::REG_REQUESTED_LEVEL: cfg_reg.requested_level <= cfg_wdata[7:0];
                sps_pkg::REG_STIM_MODE:       cfg_reg.stim_mode       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Step logic
    sps_step u_step (
        .state_i      (st_reg),
        .cfg_i        (cfg_reg),
        .timestamp    (s_timestamp),
        .stim_request (s_stim_request),
        .bad_frame    (s_bad_frame),
        .state_o      (st_next),
        .written_o    (written_next)
    );

    assign res_next = '{st: st_next, written: written_next};

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = m_valid_reg && m_ready;

    // Sequencer state advances on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (push) begin
            st_reg <= st_next;
        end
    end

    // Result buffer: output register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg || pop) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload of the result buffer
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!m_valid_reg || pop) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_phase           = out_reg.st.phase;
    assign m_drive_level     = out_reg.st.drive;
    assign m_drive_written   = out_reg.written;
    assign m_entry_count     = out_reg.st.entries;
    assign m_stim_count      = out_reg.st.stimuli;
    assign m_first_stim_time = out_reg.st.first_stim;
    assign m_good_frames     = out_reg.st.good_count;
    assign m_bad_frames      = out_reg.st.bad_count;

    // Checks
    `SPS_ASSERT(a_skid_behind_out, skid_valid_reg |-> m_valid_reg, "skid full, output empty")
    `SPS_ASSERT(a_stall_skid, (push && m_valid_reg && !m_ready) |=> skid_valid_reg, "item lost")
    `SPS_ASSERT(a_drive_in_stim, (|st_reg.drive) |-> st_reg.phase == sps_pkg::PH_STIM, "drive on")
    `SPS_ASSERT(a_phase_code, st_reg.phase <= sps_pkg::PH_REFRACT, "phase code out of range")
    `SPS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (!m_valid_reg && !skid_valid_reg), "not empty")

endmodule

[hw/rtl/sps_step.sv]
// One frame of the phase sequencer: state in, next state out.
module sps_step (
    input  sps_pkg::state_t state_i,
    input  sps_pkg::cfg_t   cfg_i,
    input  logic [31:0]     timestamp,
    input  logic            stim_request,
    input  logic            bad_frame,
    output sps_pkg::state_t state_o,
    output logic            written_o
);

    logic [31:0] span;
    logic [31:0] elapsed;
    logic        expired;
    logic [2:0]  on_level;

    // Pick the duration that matters in this phase, then one subtract/compare
    always_comb begin
        case (state_i.phase)
            sps_pkg::PH_DELAYING: span = cfg_i.entry_delay;
            sps_pkg::PH_STIM:     span = cfg_i.stim_length;
            sps_pkg::PH_PAUSE:    span = cfg_i.pause_delay;
            sps_pkg::PH_REFRACT:  span = cfg_i.refractory_time;
            default:              span = 32'd0;
        endcase
    end

    assign elapsed = timestamp - state_i.last_change;
    assign expired = elapsed > span;

    // Light mode only switches on or off
    always_comb begin
        on_level = sps_pkg::clamp_level(cfg_i.requested_level);
        if (cfg_i.stim_mode) begin
            on_level = {2'b00, (on_level != 3'd0)};
        end
    end

    // Phase transitions
    always_comb begin
        state_o   = state_i;
        written_o = 1'b0;

        if (bad_frame) begin
            state_o.bad_count = state_i.bad_count + 32'd1;
        end else begin
            state_o.good_count = state_i.good_count + 32'd1;
        end

        case (state_i.phase)
            sps_pkg::PH_OUTSIDE: begin
                if (stim_request) begin
                    state_o.phase       = sps_pkg::PH_DELAYING;
                    state_o.entries     = state_i.entries + 32'd1;
                    state_o.last_change = timestamp;
                end
            end
            sps_pkg::PH_DELAYING: begin
                if (!bad_frame) begin
                    if (!stim_request) begin
                        state_o.phase = sps_pkg::PH_OUTSIDE;
                    end else if (expired) begin
                        state_o.phase       = sps_pkg::PH_STIM;
                        state_o.stimuli     = state_i.stimuli + 32'd1;
                        state_o.last_change = timestamp;
                        state_o.drive       = on_level;
                        written_o           = 1'b1;
                        if (state_i.first_stim == 32'd0) begin
                            state_o.first_stim = timestamp;
                        end
                    end
                end
            end
            sps_pkg::PH_STIM: begin
                // an expired stimulus goes off even on a bad frame
                if (expired) begin
                    state_o.drive = 3'd0;
                    written_o     = 1'b1;
                    if (!bad_frame) begin
                        state_o.phase = stim_request ? sps_pkg::PH_PAUSE
                                                     : sps_pkg::PH_REFRACT;
                        state_o.last_change = timestamp;
                    end
                end
            end
            sps_pkg::PH_PAUSE: begin
                if (!bad_frame) begin
                    if (!stim_request) begin
                        state_o.phase       = sps_pkg::PH_REFRACT;
                        state_o.last_change = timestamp;
                    end else if (expired) begin
                        state_o.phase       = sps_pkg::PH_STIM;
                        state_o.stimuli     = state_i.stimuli + 32'd1;
                        state_o.last_change = timestamp;
                        state_o.drive       = on_level;
                        written_o           = 1'b1;
                    end
                end
            end
            sps_pkg::PH_REFRACT: begin
                if (expired) begin
                    state_o.phase = sps_pkg::PH_OUTSIDE;
                end
            end
            default: begin
                state_o.phase = state_i.phase;
            end
        endcase
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;

    // One frame outcome as the block reports it
    typedef struct {
        logic [2:0]  phase;
        logic [2:0]  drive;
        logic        written;
        logic [31:0] entries;
        logic [31:0] stims;
        logic [31:0] first_ms;
        logic [31:0] good;
        logic [31:0] bad;
    } frame_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [31:0]                    s_timestamp = '0;
    logic                           s_stim_request = 1'b0;
    logic                           s_bad_frame = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [2:0]                     m_phase;
    logic [2:0]                     m_drive_level;
    logic                           m_drive_written;
    logic [31:0]                    m_entry_count;
    logic [31:0]                    m_stim_count;
    logic [31:0]                    m_first_stim_time;
    logic [31:0]                    m_good_frames;
    logic [31:0]                    m_bad_frames;

    stimulus_phase_sequencer_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_timestamp       (s_timestamp),
        .s_stim_request    (s_stim_request),
        .s_bad_frame       (s_bad_frame),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_phase           (m_phase),
        .m_drive_level     (m_drive_level),
        .m_drive_written   (m_drive_written),
        .m_entry_count     (m_entry_count),
        .m_stim_count      (m_stim_count),
        .m_first_stim_time (m_first_stim_time),
        .m_good_frames     (m_good_frames),
        .m_bad_frames      (m_bad_frames)
    );

    // Sequencer prediction state and the settings it runs under
    sps_pkg::cfg_t active_cfg = '0;
    logic [2:0]    seq_phase = sps_pkg::PH_OUTSIDE;
    logic [31:0]   mark_ms = '0;
    logic [2:0]    drive_now = '0;
    logic [31:0]   n_entries = '0;
    logic [31:0]   n_stims = '0;
    logic [31:0]   first_ms = '0;
    logic [31:0]   n_good = '0;
    logic [31:0]   n_bad = '0;

    frame_result_t pending_frames[$];
    int            mismatches = 0;
    int            results_seen = 0;
    int            cycle_count = 0;
    bit            idle_on = 1'b1;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("stimulus_phase_sequencer_core regression: fail");
            $finish;
        end
    end

    // Level put on the output when a stimulus starts
    function automatic logic [2:0] stim_on_level();
        logic [7:0] lv;
        logic [2:0] lvl;
        lv = active_cfg.requested_level;
        if (lv >= sps_pkg::LEVEL_MAX) begin
            lvl = 3'd7;
        end else if (lv >= sps_pkg::LEVEL_MIN) begin
            lvl = lv[2:0];
        end else begin
            lvl = 3'd0;
        end
        if (active_cfg.stim_mode) begin
            lvl = (lvl != 3'd0) ? 3'd1 : 3'd0;
        end
        return lvl;
    endfunction

    // One frame through the phase sequencer; returns the outcome after it
    function automatic frame_result_t advance_sequencer(logic [31:0] ts, bit req, bit bad);
        frame_result_t r;
        logic [31:0]   held;
        bit            wr;
        held = ts - mark_ms;
        wr = 1'b0;
        if (bad) begin
            n_bad = n_bad + 32'd1;
        end else begin
            n_good = n_good + 32'd1;
        end
        case (seq_phase)
            sps_pkg::PH_OUTSIDE: begin
                if (req) begin
                    seq_phase = sps_pkg::PH_DELAYING;
                    n_entries = n_entries + 32'd1;
                    mark_ms = ts;
                end
            end
            sps_pkg::PH_DELAYING: begin
                if (!bad) begin
                    if (!req) begin
                        seq_phase = sps_pkg::PH_OUTSIDE;
                    end else if (held > active_cfg.entry_delay) begin
                        seq_phase = sps_pkg::PH_STIM;
                        n_stims = n_stims + 32'd1;
                        // a first stimulus at time zero is taken again later
                        if (first_ms == 32'd0) first_ms = ts;
                        mark_ms = ts;
                        drive_now = stim_on_level();
                        wr = 1'b1;
                    end
                end
            end
            sps_pkg::PH_STIM: begin
                // expired stimulus is switched off even on a bad frame
                if (held > active_cfg.stim_length) begin
                    drive_now = 3'd0;
                    wr = 1'b1;
                    if (!bad) begin
                        seq_phase = req ? sps_pkg::PH_PAUSE : sps_pkg::PH_REFRACT;
                        mark_ms = ts;
                    end
                end
            end
            sps_pkg::PH_PAUSE: begin
                if (!bad) begin
                    if (!req) begin
                        seq_phase = sps_pkg::PH_REFRACT;
                        mark_ms = ts;
                    end else if (held > active_cfg.pause_delay) begin
                        seq_phase = sps_pkg::PH_STIM;
                        n_stims = n_stims + 32'd1;
                        mark_ms = ts;
                        drive_now = stim_on_level();
                        wr = 1'b1;
                    end
                end
            end
            sps_pkg::PH_REFRACT: begin
                if (held > active_cfg.refractory_time) seq_phase = sps_pkg::PH_OUTSIDE;
            end
            default: begin
            end
        endcase
        r.phase = seq_phase;
        r.drive = drive_now;
        r.written = wr;
        r.entries = n_entries;
        r.stims = n_stims;
        r.first_ms = first_ms;
        r.good = n_good;
        r.bad = n_bad;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches = mismatches + 1;
        if (mismatches <= 40) begin
            $display("mismatch on result %0d, %s: got %0h, expected %0h",
                     results_seen, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Result side: random back-pressure
    always @(posedge aclk) begin
        m_ready <= !(idle_on && $urandom_range(0, 99) < 6);
    end

    // Result checking against the oldest predicted frame
    always @(posedge aclk) begin : check_results
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen = results_seen + 1;
            if (pending_frames.size() == 0) begin
                report_mismatch("result with nothing pending", 32'd0, 32'd0);
            end else begin
                want = pending_frames.pop_front();
                check_field("phase", 32'(m_phase), 32'(want.phase));
                check_field("drive_level", 32'(m_drive_level), 32'(want.drive));
                check_field("drive_written", 32'(m_drive_written), 32'(want.written));
                check_field("entry_count", m_entry_count, want.entries);
                check_field("stim_count", m_stim_count, want.stims);
                check_field("first_stim_time", m_first_stim_time, want.first_ms);
                check_field("good_frames", m_good_frames, want.good);
                check_field("bad_frames", m_bad_frames, want.bad);
            end
        end
    end

    // Present one frame and wait for it to be taken; predict on accept
    task automatic send_frame(input logic [31:0] ts, input bit req, input bit bad);
        if (idle_on && $urandom_range(0, 99) < 3) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_timestamp <= ts;
        s_stim_request <= req;
        s_bad_frame <= bad;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_frames.push_back(advance_sequencer(ts, req, bad));
    endtask

    // Stop sending and wait for every pending result to be checked
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_frames.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sps_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Write all six registers; only called with nothing in flight
    task automatic apply_config(input sps_pkg::cfg_t c);
        write_reg(sps_pkg::REG_ENTRY_DELAY, c.entry_delay);
        write_reg(sps_pkg::REG_PAUSE_DELAY, c.pause_delay);
        write_reg(sps_pkg::REG_STIM_LENGTH, c.stim_length);
        write_reg(sps_pkg::REG_REFRACTORY_TIME, c.refractory_time);
        write_reg(sps_pkg::REG_REQUESTED_LEVEL, {24'd0, c.requested_level});
        write_reg(sps_pkg::REG_STIM_MODE, {31'd0, c.stim_mode});
        cfg_we <= 1'b0;
        active_cfg = c;
    endtask

    function automatic logic [31:0] pick_span();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'd0;
            1: v = 32'hFFFF_FFFF;
            2: v = $urandom;
            default: v = $urandom_range(1, 200);
        endcase
        return v;
    endfunction

    // Full walk through all phases, boundaries and bad-frame freezes
    task automatic test_basic_phase_walk();
        sps_pkg::cfg_t c;
        drain();
        c.entry_delay = 32'd10;
        c.pause_delay = 32'd5;
        c.stim_length = 32'd20;
        c.refractory_time = 32'd8;
        c.requested_level = 8'd5;
        c.stim_mode = 1'b0;
        apply_config(c);
        send_frame(32'd100, 1'b0, 1'b0);
        send_frame(32'd100, 1'b1, 1'b1);  // entry on a bad frame
        send_frame(32'd110, 1'b1, 1'b0);  // delay not yet exceeded
        send_frame(32'd111, 1'b1, 1'b1);  // bad frame holds delaying
        send_frame(32'd111, 1'b1, 1'b0);  // first stimulus
        send_frame(32'd140, 1'b1, 1'b1);  // expired on bad frame: off, stays
        send_frame(32'd142, 1'b1, 1'b0);  // to pause
        send_frame(32'd150, 1'b0, 1'b1);  // bad frame holds pause
        send_frame(32'd148, 1'b1, 1'b0);  // second stimulus
        send_frame(32'd170, 1'b0, 1'b0);  // to refractory
        send_frame(32'd180, 1'b1, 1'b1);  // refractory acts on bad frames
        send_frame(32'd181, 1'b1, 1'b0);
        send_frame(32'd182, 1'b0, 1'b0);  // request gone while delaying
    endtask

    // Timestamp wrap, stimulus at time zero, light mode and level clamping
    task automatic test_wrap_and_light_mode();
        sps_pkg::cfg_t c;
        drain();
        c.entry_delay = 32'd0;
        c.pause_delay = 32'd0;
        c.stim_length = 32'd0;
        c.refractory_time = 32'hFFFF_FFFF;
        c.requested_level = 8'd255;
        c.stim_mode = 1'b1;
        apply_config(c);
        send_frame(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_frame(32'd0, 1'b1, 1'b0);
        send_frame(32'd1, 1'b1, 1'b0);
        send_frame(32'd2, 1'b1, 1'b0);
        send_frame(32'd3, 1'b0, 1'b0);
        send_frame(32'd2, 1'b1, 1'b1);  // difference wraps to all ones
        drain();
        c.entry_delay = 32'd5;
        c.stim_length = 32'd3;
        c.refractory_time = 32'd0;
        c.requested_level = 8'd1;       // clamps to off, so light stays dark
        apply_config(c);
        send_frame(32'd10, 1'b1, 1'b1);
        send_frame(32'd11, 1'b1, 1'b1);
        send_frame(32'd20, 1'b1, 1'b0);
        send_frame(32'd30, 1'b0, 1'b1);
        drain();
        c.entry_delay = 32'd0;
        c.requested_level = 8'd8;
        c.stim_mode = 1'b0;
        apply_config(c);
        send_frame(32'd31, 1'b0, 1'b0);
        send_frame(32'd32, 1'b1, 1'b0);
        send_frame(32'd33, 1'b1, 1'b0);
        send_frame(32'd34, 1'b1, 1'b0);
    endtask

    // Mostly steady frame streams with request runs; some jumps and noise
    task automatic run_random_frames(input int count);
        logic [31:0] ts;
        bit          req;
        int          run_left;
        int          roll;
        ts = $urandom;
        req = 1'($urandom_range(0, 1));
        run_left = 0;
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                req = !req;
                run_left = $urandom_range(1, 40);
            end
            run_left = run_left - 1;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                ts = $urandom;
            end else if (roll < 7) begin
                ts = ts - $urandom_range(1, 100);
            end else begin
                ts = ts + $urandom_range(0, 60);
            end
            send_frame(ts, ($urandom_range(0, 99) < 8) ? !req : req,
                       $urandom_range(0, 99) < 10);
        end
    endtask

    // Several settings, extremes first; one setting runs without any idling
    task automatic test_random_sessions();
        sps_pkg::cfg_t c;
        for (int p = 0; p < 8; p++) begin
            drain();
            if (p == 0) begin
                c = '0;
            end else if (p == 1) begin
                c.entry_delay = 32'hFFFF_FFFF;
                c.pause_delay = 32'hFFFF_FFFF;
                c.stim_length = 32'hFFFF_FFFF;
                c.refractory_time = 32'hFFFF_FFFF;
                c.requested_level = 8'd255;
                c.stim_mode = 1'b1;
            end else begin
                c.entry_delay = pick_span();
                c.pause_delay = pick_span();
                c.stim_length = pick_span();
                c.refractory_time = pick_span();
                c.requested_level = $urandom_range(0, 1) ? 8'($urandom_range(0, 9))
                                                          : 8'($urandom_range(0, 255));
                c.stim_mode = 1'($urandom_range(0, 1));
            end
            idle_on = (p != 4);
            apply_config(c);
            run_random_frames(90);
            drain();
            run_random_frames(85);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_phase_walk();
        test_wrap_and_light_mode();
        test_random_sessions();
        drain();
        if (mismatches == 0) begin
            $display("stimulus_phase_sequencer_core regression: pass");
        end else begin
            $display("stimulus_phase_sequencer_core regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/sps_pkg.sv
hw/rtl/sps_step.sv
hw/rtl/stimulus_phase_sequencer_core.sv
tb/sv/tb_top.sv
